// ===== src/bmhq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

  localparam int KEY_WIDTH = 32;
  localparam int COUNT_W   = 11;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_INCREASE = 2'd2,
    OP_DECREASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]                  operation;
    logic signed [KEY_WIDTH-1:0] key;
    logic [COUNT_W-1:0]          position;
  } req_item_t;

  typedef struct packed {
    logic signed [KEY_WIDTH-1:0] extracted_key;
    logic signed [KEY_WIDTH-1:0] top_key;
    logic [COUNT_W-1:0]          entry_count;
    logic [1:0]                  status;
  } rsp_item_t;

  // Program addresses of the sequencer.
  typedef enum logic [3:0] {
    P_IDLE,
    P_INS,
    P_EXT,
    P_EXT_LOAD,
    P_KEY,
    P_KEY_SEL,
    P_UP_READ,
    P_UP_MOVE,
    P_DN_READ,
    P_DN_MOVE,
    P_FINAL,
    P_DONE
  } pc_t;

  // Branch conditions. A step jumps to t_true when its condition holds and
  // otherwise acts and goes to t_false, or by operation if it dispatches.
  typedef enum logic [3:0] {
    C_FALSE,
    C_NO_INPUT,
    C_FULL,
    C_EMPTY,
    C_BADPOS,
    C_OP_DEC,
    C_ROOT,
    C_UP_STOP,
    C_NO_CHILD,
    C_DN_STOP,
    C_OUT_BUSY
  } cond_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_INS_INIT,
    A_EXT_INIT,
    A_EXT_LOAD,
    A_KEY_INIT,
    A_UP_READ,
    A_UP_MOVE,
    A_DN_READ,
    A_DN_MOVE,
    A_FINAL,
    A_RESULT
  } act_t;

  typedef struct packed {
    cond_t   cond;
    act_t    act;
    status_t stat;
    logic    dispatch;
    pc_t     t_true;
    pc_t     t_false;
  } ctl_word_t;

  // The control store.
  function automatic ctl_word_t ucode(input pc_t pc);
    ctl_word_t w;
    case (pc)
      P_IDLE:     w = '{cond: C_NO_INPUT, act: A_NONE, stat: ST_OK, dispatch: 1'b1,
                        t_true: P_IDLE, t_false: P_IDLE};
      P_INS:      w = '{cond: C_FULL, act: A_INS_INIT, stat: ST_FULL, dispatch: 1'b0,
                        t_true: P_DONE, t_false: P_UP_READ};
      P_EXT:      w = '{cond: C_EMPTY, act: A_EXT_INIT, stat: ST_EMPTY, dispatch: 1'b0,
                        t_true: P_DONE, t_false: P_EXT_LOAD};
      P_EXT_LOAD: w = '{cond: C_FALSE, act: A_EXT_LOAD, stat: ST_OK, dispatch: 1'b0,
                        t_true: P_DN_READ, t_false: P_DN_READ};
      P_KEY:      w = '{cond: C_BADPOS, act: A_KEY_INIT, stat: ST_BADPOS, dispatch: 1'b0,
                        t_true: P_DONE, t_false: P_KEY_SEL};
      P_KEY_SEL:  w = '{cond: C_OP_DEC, act: A_NONE, stat: ST_OK, dispatch: 1'b0,
                        t_true: P_DN_READ, t_false: P_UP_READ};
      P_UP_READ:  w = '{cond: C_ROOT, act: A_UP_READ, stat: ST_OK, dispatch: 1'b0,
                        t_true: P_FINAL, t_false: P_UP_MOVE};
      P_UP_MOVE:  w = '{cond: C_UP_STOP, act: A_UP_MOVE, stat: ST_OK, dispatch: 1'b0,
                        t_true: P_FINAL, t_false: P_UP_READ};
      P_DN_READ:  w = '{cond: C_NO_CHILD, act: A_DN_READ, stat: ST_OK, dispatch: 1'b0,
                        t_true: P_FINAL, t_false: P_DN_MOVE};
      P_DN_MOVE:  w = '{cond: C_DN_STOP, act: A_DN_MOVE, stat: ST_OK, dispatch: 1'b0,
                        t_true: P_FINAL, t_false: P_DN_READ};
      P_FINAL:    w = '{cond: C_FALSE, act: A_FINAL, stat: ST_OK, dispatch: 1'b0,
                        t_true: P_DONE, t_false: P_DONE};
      P_DONE:     w = '{cond: C_OUT_BUSY, act: A_RESULT, stat: ST_OK, dispatch: 1'b0,
                        t_true: P_DONE, t_false: P_IDLE};
      default:    w = '{cond: C_FALSE, act: A_NONE, stat: ST_OK, dispatch: 1'b0,
                        t_true: P_IDLE, t_false: P_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/binary_max_heap_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Binary max-heap priority queue of signed keys. Each request transaction
// carries an operation (insert, extract max, increase key or decrease key),
// a key and a 1-based position, and produces exactly one response
// transaction with the removed root (zero unless an extract succeeded), the
// maximum left in the heap (zero when empty), the number of keys held and a
// status: ok, empty on extract, full on insert, or a bad position (zero or
// above the count) on a key change; a failed request changes nothing. The
// keys live in a dual-read RAM of CAPACITY entries and a small microcoded
// sequencer walks the heap with a read step and a move step per level. A
// failed request goes from its check step straight to the result step. The
// longest request is a key change that walks the full height of the tree,
// floor(log2(CAPACITY)) levels; the sift loop, with its RAM reads and compares
// at each level, sets how long such a request takes.
// Requests are handled one at a time; the next one can be accepted in the
// cycle in which the previous response appears in the output register, even
// while that response is still stalled. Increase and decrease key do not
// check the direction of the change, so a key moved the wrong way stays
// put and may leave the heap out of order. The RAM needs no clearing after
// reset: only entries below the count are ever used. CAPACITY may range
// from 2 to 2047, the count being 11 bits.
module binary_max_heap_queue_top #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire bmhq_pkg::req_item_t  req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output bmhq_pkg::rsp_item_t       rsp
);

  import bmhq_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  // Wide enough for the child index of any slot next to the count.
  localparam int CMP_W  = COUNT_W + 1;
  localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

  // Sequencer state and the current control word.
  pc_t       pc;
  pc_t       pc_next;
  ctl_word_t cw;
  logic      cond_true;
  logic      accept;

  // Datapath registers.
  op_t                         op_r;
  logic [COUNT_W-1:0]          pos_r;
  logic signed [KEY_WIDTH-1:0] val;
  logic [ADDR_W-1:0]           slot;
  logic [COUNT_W-1:0]          count;
  logic signed [KEY_WIDTH-1:0] extracted;
  status_t                     status;
  logic signed [KEY_WIDTH-1:0] top;

  // RAM port signals.
  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic [ADDR_W-1:0]    raddr_a;
  logic [ADDR_W-1:0]    raddr_b;
  logic [KEY_WIDTH-1:0] rdata_a;
  logic [KEY_WIDTH-1:0] rdata_b;

  // Index arithmetic and compares.
  logic [CMP_W-1:0]            left_w;
  logic [CMP_W-1:0]            right_w;
  logic [CMP_W-1:0]            count_w;
  logic [ADDR_W-1:0]           parent;
  logic [ADDR_W-1:0]           last_addr;
  logic signed [KEY_WIDTH-1:0] rd_a;
  logic signed [KEY_WIDTH-1:0] rd_b;
  logic                        pick_right;
  logic signed [KEY_WIDTH-1:0] pick_val;
  logic [ADDR_W-1:0]           pick_addr;

  bmhq_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .rdata_a(rdata_a),
    .raddr_b(raddr_b),
    .rdata_b(rdata_b)
  );

  assign cw        = ucode(pc);
  assign req_stall = (pc != P_IDLE);
  assign accept    = req_valid && (pc == P_IDLE);

  assign left_w     = CMP_W'({slot, 1'b1});
  assign right_w    = left_w + CMP_W'(1);
  assign count_w    = CMP_W'(count);
  assign parent     = (slot - 1'b1) >> 1;
  assign last_addr  = ADDR_W'(count - 1'b1);
  assign rd_a       = $signed(rdata_a);
  assign rd_b       = $signed(rdata_b);
  // The left child wins ties; the right one only when strictly larger.
  assign pick_right = (right_w < count_w) && (rd_a < rd_b);
  assign pick_val   = pick_right ? rd_b : rd_a;
  assign pick_addr  = pick_right ? right_w[ADDR_W-1:0] : left_w[ADDR_W-1:0];

  // Condition select for the current step.
  always_comb begin
    case (cw.cond)
      C_FALSE:    cond_true = 1'b0;
      C_NO_INPUT: cond_true = !req_valid;
      C_FULL:     cond_true = (count == CAP_COUNT);
      C_EMPTY:    cond_true = (count == '0);
      C_BADPOS:   cond_true = (pos_r == '0) || (pos_r > count);
      C_OP_DEC:   cond_true = (op_r == OP_DECREASE);
      C_ROOT:     cond_true = (slot == '0);
      C_UP_STOP:  cond_true = !(rd_a < val);
      C_NO_CHILD: cond_true = (left_w >= count_w);
      C_DN_STOP:  cond_true = !(pick_val > val);
      C_OUT_BUSY: cond_true = rsp_valid && rsp_stall;
      default:    cond_true = 1'b0;
    endcase
  end

  // Next program address.
  always_comb begin
    if (cond_true) begin
      pc_next = cw.t_true;
    end else if (cw.dispatch) begin
      case (op_t'(req.operation))
        OP_INSERT:  pc_next = P_INS;
        OP_EXTRACT: pc_next = P_EXT;
        default:    pc_next = P_KEY;
      endcase
    end else begin
      pc_next = cw.t_false;
    end
  end

  // RAM controls decoded from the control word.
  always_comb begin
    we      = 1'b0;
    waddr   = slot;
    wdata   = val;
    raddr_a = '0;
    raddr_b = '0;
    if (!cond_true) begin
      case (cw.act)
        A_EXT_INIT: raddr_a = last_addr;
        A_UP_READ:  raddr_a = parent;
        A_UP_MOVE: begin
          we    = 1'b1;
          wdata = rdata_a;
        end
        A_DN_READ: begin
          raddr_a = left_w[ADDR_W-1:0];
          raddr_b = right_w[ADDR_W-1:0];
        end
        A_DN_MOVE: begin
          we    = 1'b1;
          wdata = pick_val;
        end
        A_FINAL:    we = 1'b1;
        default:    we = 1'b0;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= P_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (!cond_true && cw.act == A_INS_INIT) begin
        count <= count + 1'b1;
      end else if (!cond_true && cw.act == A_EXT_INIT) begin
        count <= count - 1'b1;
      end
      if (!cond_true && cw.act == A_RESULT) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= op_t'(req.operation);
      pos_r     <= req.position;
      val       <= req.key;
      status    <= ST_OK;
      extracted <= '0;
    end
    if (cond_true && cw.stat != ST_OK) begin
      status <= cw.stat;
    end
    if (!cond_true) begin
      case (cw.act)
        A_INS_INIT: slot <= count[ADDR_W-1:0];
        A_EXT_INIT: extracted <= top;
        A_EXT_LOAD: begin
          val  <= rd_a;
          slot <= '0;
        end
        A_KEY_INIT: slot <= ADDR_W'(pos_r - 1'b1);
        A_UP_MOVE:  slot <= parent;
        A_DN_MOVE:  slot <= pick_addr;
        A_RESULT: begin
          rsp.extracted_key <= extracted;
          rsp.top_key       <= (count != '0) ? top : '0;
          rsp.entry_count   <= count;
          rsp.status        <= status;
        end
        default: begin
        end
      endcase
    end
    // Shadow copy of the root so the maximum needs no extra RAM read.
    if (we && waddr == '0) begin
      top <= $signed(wdata);
    end
  end

endmodule

`default_nettype wire

// ===== src/bmhq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One write port, two read ports, registered read data.
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== src/bmhq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmhq_checker #(
  parameter int CAPACITY = 1024
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_stall,
  input wire logic                rsp_valid,
  input wire logic                rsp_stall,
  input wire bmhq_pkg::rsp_item_t rsp
);

  import bmhq_pkg::*;

  localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

  // The count never exceeds the capacity.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.entry_count <= CAP_COUNT)
    else $error("entry count above capacity");

  // A failed request reports no removed key.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.extracted_key == '0)
    else $error("failed request reports an extracted key");

  // An empty heap reports a zero maximum.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.entry_count == '0 |-> rsp.top_key == '0)
    else $error("nonzero maximum on an empty heap");

  // An accepted request makes the request side stall, so no two requests are accepted back to back.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted in back-to-back cycles");

  // A stalled response holds.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

endmodule

bind binary_max_heap_queue_top bmhq_checker #(.CAPACITY(CAPACITY)) u_bmhq_checker (.*);

`default_nettype wire
